### src/assert_macros.svh
// Assertion macros for the checker file of the alignment block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GASM_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gasm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GASM_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gasm assertion failed");

`endif

### src/gasm_pkg.sv
// Types, constants and helper functions for the global alignment score block.
package gasm_pkg;

  localparam int MAX_QUERY_LEN = 256;
  localparam int MAX_REF_LEN   = 4096;

  localparam int QIDX_W    = $clog2(MAX_QUERY_LEN);
  localparam int CNT_W     = $clog2(MAX_QUERY_LEN + 1);
  localparam int COL_W     = $clog2(MAX_REF_LEN + 1);
  localparam int SCORE_W   = 18;
  localparam int AWARD_W   = 5;
  localparam int SYM_W     = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [AWARD_W-1:0] award_t;

  localparam score_t SCORE_MAX = score_t'({1'b0, {(SCORE_W-1){1'b1}}});
  localparam score_t SCORE_MIN = score_t'({1'b1, {(SCORE_W-1){1'b0}}});

  localparam award_t MATCH_RST    = award_t'(1);
  localparam award_t MISMATCH_RST = award_t'(-1);
  localparam award_t GAP_RST      = award_t'(-2);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_REF  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH    = 2'd0,
    REG_MISMATCH = 2'd1,
    REG_GAP      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    award_t match_aw;
    award_t mismatch_aw;
    award_t gap_aw;
  } awards_t;

  // Query symbol write into one cell of the chain.
  typedef struct packed {
    logic              we;
    logic [QIDX_W-1:0] idx;
    logic [SYM_W-1:0]  sym;
  } qload_t;

  // One reference column travelling down the chain of cells.
  typedef struct packed {
    logic             first;
    logic [SYM_W-1:0] sym;
    logic [CNT_W-1:0] rem;
    score_t           cur;
    score_t           up;
    logic [COL_W-1:0] col;
    logic             fin;
    logic             trunc;
  } col_tok_t;

  // Saturating add of an award to a score.
  function automatic score_t sat_add(score_t a, award_t b);
    logic [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {{(SCORE_W+1-AWARD_W){b[AWARD_W-1]}}, b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      sat_add = s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      sat_add = score_t'(s[SCORE_W-1:0]);
    end
  endfunction

endpackage

### src/global_alignment_score_matrix_top.sv
// Global alignment score engine (linear gap) built as a chain of scoring cells.
//
// Usage: load the query one byte per word with action_i low (up to 256
// symbols; further loads, and loads while a reference stream is open, are
// dropped and reported through query_truncated_o). Then stream reference
// symbols with action_i high, one word per clock if desired; busy_o is never
// raised, so a word is taken at every edge where start_i is high. Each
// reference word yields exactly one result, column_score_o being the
// bottom-row score of that column, with result_valid_o high for one cycle.
// The result of the word with last_symbol_i set is the global alignment
// score; that word also closes the alignment. A result passes one entry
// register that forms the column's top border, then one pipeline stage per
// query cell (256 cells, unused cells pass the score through). The receiver
// cannot stall, so a result must be captured in its cycle. Award registers
// may only be changed while no reference word is in flight, i.e. once the
// result of the last one has been taken.
module global_alignment_score_matrix_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           action_i,
  input  logic [gasm_pkg::SYM_W-1:0]     symbol_i,
  input  logic                           last_symbol_i,
  input  logic                           cfg_we_i,
  input  logic [gasm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gasm_pkg::AWARD_W-1:0]   cfg_wdata_i,
  output logic                           result_valid_o,
  output gasm_pkg::score_t               column_score_o,
  output logic [gasm_pkg::COL_W-1:0]     column_index_o,
  output logic                           final_res_o,
  output logic                           query_truncated_o
);
  import gasm_pkg::*;

  awards_t  awards;
  qload_t   load;
  logic     accept;
  logic     vld [0:MAX_QUERY_LEN];
  col_tok_t tok [0:MAX_QUERY_LEN];

  // Each cell computes its row of a column combinationally and registers it,
  // so a new word can enter every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  gasm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (action_i),
    .symbol_i      (symbol_i),
    .last_symbol_i (last_symbol_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (award_t'(cfg_wdata_i)),
    .awards_o      (awards),
    .load_o        (load),
    .valid_o       (vld[0]),
    .tok_o         (tok[0])
  );

  // Cell i holds query symbol i and the score of row i+1; a column word
  // moves one cell down per cycle, carrying the score just above it.
  for (genvar i = 0; i < MAX_QUERY_LEN; i++) begin : g_cell
    gasm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (QIDX_W'(i)),
      .awards_i (awards),
      .load_i   (load),
      .valid_i  (vld[i]),
      .tok_i    (tok[i]),
      .valid_o  (vld[i+1]),
      .tok_o    (tok[i+1])
    );
  end

  // The last cell's registers drive the result ports directly.
  assign result_valid_o    = vld[MAX_QUERY_LEN];
  assign column_score_o    = tok[MAX_QUERY_LEN].cur;
  assign column_index_o    = tok[MAX_QUERY_LEN].col;
  assign final_res_o       = tok[MAX_QUERY_LEN].fin;
  assign query_truncated_o = tok[MAX_QUERY_LEN].trunc;

endmodule

### src/gasm_cell.sv
// One cell of the systolic chain: holds one query symbol and its row score.
module gasm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gasm_pkg::QIDX_W-1:0] idx_i,
  input  gasm_pkg::awards_t         awards_i,
  input  gasm_pkg::qload_t          load_i,
  input  logic                      valid_i,
  input  gasm_pkg::col_tok_t        tok_i,
  output logic                      valid_o,
  output gasm_pkg::col_tok_t        tok_o
);
  import gasm_pkg::*;

  logic [SYM_W-1:0] q_q;
  score_t           p_q;
  logic             valid_q;
  col_tok_t         tok_q, tok_d;
  logic             active;
  award_t           diag_aw;
  score_t           old_sc, diag_sc, del_sc, ins_sc, best;

  always_comb begin
    active  = valid_i && (tok_i.rem != '0);
    diag_aw = (q_q == tok_i.sym) ? awards_i.match_aw : awards_i.mismatch_aw;
    // On the first column the row score comes from the left border.
    old_sc  = tok_i.first ? sat_add(tok_i.up, awards_i.gap_aw) : p_q;
    diag_sc = sat_add(tok_i.up, diag_aw);
    del_sc  = sat_add(tok_i.cur, awards_i.gap_aw);
    ins_sc  = sat_add(old_sc, awards_i.gap_aw);
    best    = diag_sc;
    if (del_sc > best) begin
      best = del_sc;
    end
    if (ins_sc > best) begin
      best = ins_sc;
    end
    tok_d    = tok_i;
    tok_d.up = old_sc;
    if (tok_i.rem != '0) begin
      tok_d.cur = best;
      tok_d.rem = tok_i.rem - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (active) begin
      p_q <= best;
    end
    if (load_i.we && (load_i.idx == idx_i)) begin
      q_q <= load_i.sym;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

### src/gasm_ctrl.sv
// Front end: award registers, query and column counters, column word issue.
module gasm_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           action_i,
  input  logic [gasm_pkg::SYM_W-1:0]     symbol_i,
  input  logic                           last_symbol_i,
  input  logic                           cfg_we_i,
  input  logic [gasm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  gasm_pkg::award_t               cfg_wdata_i,
  output gasm_pkg::awards_t              awards_o,
  output gasm_pkg::qload_t               load_o,
  output logic                           valid_o,
  output gasm_pkg::col_tok_t             tok_o
);
  import gasm_pkg::*;

  localparam int PROD_W = COL_W + AWARD_W + 1;
  localparam logic signed [PROD_W-1:0] PMAX = PROD_W'(SCORE_MAX);
  localparam logic signed [PROD_W-1:0] PMIN = PROD_W'(SCORE_MIN);

  awards_t          awards_q, awards_d;
  logic [CNT_W-1:0] qcnt_q, qcnt_d;
  logic [COL_W-1:0] rcnt_q, rcnt_d;
  logic             ovf_q, ovf_d;
  score_t           top_q, top_d;
  logic             valid_q, valid_d;
  col_tok_t         tok_q, tok_d;
  logic [COL_W-1:0] col;
  logic             first;
  logic signed [PROD_W-1:0] prod;
  score_t           border;

  always_comb begin
    awards_d = awards_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MATCH:    awards_d.match_aw    = cfg_wdata_i;
        REG_MISMATCH: awards_d.mismatch_aw = cfg_wdata_i;
        REG_GAP:      awards_d.gap_aw      = cfg_wdata_i;
        default:      awards_d             = awards_q;
      endcase
    end
  end

  always_comb begin
    first = (rcnt_q == '0);
    col   = (rcnt_q < COL_W'(MAX_REF_LEN)) ? rcnt_q + 1'b1 : rcnt_q;
    prod  = $signed({1'b0, col}) * awards_q.gap_aw;
    if (prod > PMAX) begin
      border = SCORE_MAX;
    end else if (prod < PMIN) begin
      border = SCORE_MIN;
    end else begin
      border = score_t'(prod[SCORE_W-1:0]);
    end

    qcnt_d     = qcnt_q;
    rcnt_d     = rcnt_q;
    ovf_d      = ovf_q;
    top_d      = top_q;
    valid_d    = 1'b0;
    load_o.we  = 1'b0;
    load_o.idx = qcnt_q[QIDX_W-1:0];
    load_o.sym = symbol_i;

    tok_d.first = first;
    tok_d.sym   = symbol_i;
    tok_d.rem   = qcnt_q;
    tok_d.cur   = border;
    tok_d.up    = first ? '0 : top_q;
    tok_d.col   = col;
    tok_d.fin   = last_symbol_i;
    tok_d.trunc = ovf_q;

    if (accept_i) begin
      if (action_i == ACT_LOAD) begin
        if (first && (qcnt_q < CNT_W'(MAX_QUERY_LEN))) begin
          load_o.we = 1'b1;
          qcnt_d    = qcnt_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        valid_d = 1'b1;
        top_d   = border;
        rcnt_d  = col;
        if (last_symbol_i) begin
          qcnt_d = '0;
          rcnt_d = '0;
          ovf_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awards_q <= '{match_aw: MATCH_RST, mismatch_aw: MISMATCH_RST, gap_aw: GAP_RST};
      qcnt_q   <= '0;
      rcnt_q   <= '0;
      ovf_q    <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      awards_q <= awards_d;
      qcnt_q   <= qcnt_d;
      rcnt_q   <= rcnt_d;
      ovf_q    <= ovf_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    tok_q <= tok_d;
  end

  assign awards_o = awards_q;
  assign valid_o  = valid_q;
  assign tok_o    = tok_q;

endmodule

### src/gasm_checker.sv
// Port-level checker for the alignment block, bound to the top level.
`include "assert_macros.svh"

module gasm_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_o,
  input  logic                       action_i,
  input  logic                       result_valid_o,
  input  logic [gasm_pkg::COL_W-1:0] column_index_o,
  input  logic                       final_res_o,
  input  logic                       query_truncated_o
);
  import gasm_pkg::*;

  localparam int LAT = MAX_QUERY_LEN + 1;

  logic             ref_acc;
  logic             col_one;
  logic             open_trunc;
  logic             col_step_ok;
  logic [COL_W-1:0] prev_col_q;

  always_ff @(posedge clk_i) begin
    prev_col_q <= column_index_o;
  end

  assign ref_acc     = start_i && !busy_o && (action_i == ACT_REF);
  assign col_one     = (column_index_o == COL_W'(1));
  assign open_trunc  = result_valid_o && query_truncated_o && !final_res_o;
  assign col_step_ok = (column_index_o == prev_col_q + 1'b1) || (column_index_o == prev_col_q);

  // Every result comes from a reference word accepted earlier, through the entry register and every cell.
  `GASM_ASSERT_IMP(a_latency, clk_i, rst_ni, result_valid_o, $past(ref_acc, LAT))

  // A result right after a final one opens a new alignment at column one.
  `GASM_ASSERT_NXT(a_restart, clk_i, rst_ni, result_valid_o && final_res_o, !result_valid_o || col_one)

  // Back-to-back results within one alignment step the column index by one or hold it at the cap.
  `GASM_ASSERT_NXT(a_col_step, clk_i, rst_ni, result_valid_o && !final_res_o, !result_valid_o || col_step_ok)

  // The truncation flag stays set until the alignment ends.
  `GASM_ASSERT_NXT(a_trunc_sticky, clk_i, rst_ni, open_trunc, !result_valid_o || query_truncated_o)

endmodule

bind global_alignment_score_matrix_top gasm_checker u_gasm_checker (.*);
